// ----- design/tangent_taylor_series_defines.svh -----
// Assertion macros shared by the tangent series design.
`ifndef TANGENT_TAYLOR_SERIES_DEFINES_SVH
`define TANGENT_TAYLOR_SERIES_DEFINES_SVH

`ifndef SYNTHESIS

`define TTAY_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tangent series check failed");

`define TTAY_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tangent series check failed");

`else

`define TTAY_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define TTAY_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/ttay_pkg.sv -----
// Types, control word layout and coefficient table for the tangent series block.
package ttay_pkg;

    localparam int ROM_SIZE = 13;
    localparam int PC_W     = 4;
    localparam int TERM_W   = 4;
    localparam int ANGLE_W  = 32;
    localparam int OUT_W    = 48;

    localparam logic [OUT_W-1:0] LIMIT_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [OUT_W-1:0] LIMIT_NEG = 48'h8000_0000_0000;

    typedef logic [PC_W-1:0] pc_t;

    // Microprogram entry points.
    localparam pc_t PC_START = 4'd0;
    localparam pc_t PC_TERM  = 4'd2;
    localparam pc_t PC_POWER = 4'd8;
    localparam pc_t PC_FIN   = 4'd14;

    typedef enum logic [1:0] {
        MA_NONE,
        MA_MAG,
        MA_PLO,
        MA_PHI
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_NONE,
        MB_MAG,
        MB_CLO,
        MB_CHI,
        MB_XLO,
        MB_XHI
    } mul_b_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD32,
        ACC_ADD64
    } acc_op_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_X2,
        OP_TERM,
        OP_POWER,
        OP_DONE
    } dp_op_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_IF_NZERO,
        J_IF_END,
        J_IF_NOVER
    } jmp_t;

    typedef struct packed {
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        acc_op_t acc_op;
        dp_op_t  dp_op;
        jmp_t    jmp;
        pc_t     target;
    } ctrl_t;

    typedef struct packed {
        logic n_zero;
        logic last_term;
        logic over;
    } stat_t;

    localparam ctrl_t CTRL_NOP = '{MA_NONE, MB_NONE, ACC_NONE, OP_NONE, J_NEXT, PC_START};

    // Rounded num * 2^62 / den by restoring division; used on constants only.
    function automatic logic [63:0] coef_q62(input logic [63:0] num, input logic [63:0] den);
        logic [65:0] q;
        logic [64:0] r;
        q = (num == den) ? 66'd1 : 66'd0;
        r = (num == den) ? 65'd0 : {1'b0, num};
        for (int b = 0; b < 63; b++) begin
            r = r << 1;
            q = q << 1;
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                q[0] = 1'b1;
            end
        end
        q = q + 66'd1;
        return q[64:1];
    endfunction

    localparam logic [63:0] COEF_ROM [ROM_SIZE] = '{
        coef_q62(64'd1, 64'd1),
        coef_q62(64'd1, 64'd3),
        coef_q62(64'd2, 64'd15),
        coef_q62(64'd17, 64'd315),
        coef_q62(64'd62, 64'd2835),
        coef_q62(64'd1382, 64'd155925),
        coef_q62(64'd21844, 64'd6081075),
        coef_q62(64'd929569, 64'd638512875),
        coef_q62(64'd6404582, 64'd10854718875),
        coef_q62(64'd443861162, 64'd1856156927625),
        coef_q62(64'd18888466084, 64'd194896477400625),
        coef_q62(64'd113927491862, 64'd49308808782358125),
        coef_q62(64'd58870668456604, 64'd3698160658676859375)
    };

endpackage

// ----- design/ttay_seq.sv -----
// Microcode sequencer: step counter, control store and conditional jumps.
module ttay_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             hold,
    input  ttay_pkg::stat_t  stat,
    output ttay_pkg::ctrl_t  cw,
    output logic             busy,
    output logic             done
);
    import ttay_pkg::*;

    pc_t  pc_reg;
    pc_t  pc_next;
    logic busy_reg;
    logic busy_next;
    logic take;

    // Each term is four partial products of p by the coefficient, then a check
    // and add; each power update is four partial products of p by x squared.
    function automatic ctrl_t micro_rom(input pc_t pc);
        ctrl_t c;
        c = CTRL_NOP;
        case (pc)
            4'd0:  c = '{MA_MAG, MB_MAG, ACC_NONE,  OP_NONE,  J_IF_NZERO, PC_FIN};
            4'd1:  c = '{MA_NONE, MB_NONE, ACC_NONE, OP_X2,   J_NEXT,     PC_START};
            4'd2:  c = '{MA_PLO, MB_CLO, ACC_NONE,  OP_NONE,  J_NEXT,     PC_START};
            4'd3:  c = '{MA_PLO, MB_CHI, ACC_LOAD,  OP_NONE,  J_NEXT,     PC_START};
            4'd4:  c = '{MA_PHI, MB_CLO, ACC_ADD32, OP_NONE,  J_NEXT,     PC_START};
            4'd5:  c = '{MA_PHI, MB_CHI, ACC_ADD32, OP_NONE,  J_NEXT,     PC_START};
            4'd6:  c = '{MA_NONE, MB_NONE, ACC_ADD64, OP_NONE, J_NEXT,    PC_START};
            4'd7:  c = '{MA_NONE, MB_NONE, ACC_NONE, OP_TERM, J_IF_END,   PC_FIN};
            4'd8:  c = '{MA_PLO, MB_XLO, ACC_NONE,  OP_NONE,  J_NEXT,     PC_START};
            4'd9:  c = '{MA_PLO, MB_XHI, ACC_LOAD,  OP_NONE,  J_NEXT,     PC_START};
            4'd10: c = '{MA_PHI, MB_XLO, ACC_ADD32, OP_NONE,  J_NEXT,     PC_START};
            4'd11: c = '{MA_PHI, MB_XHI, ACC_ADD32, OP_NONE,  J_NEXT,     PC_START};
            4'd12: c = '{MA_NONE, MB_NONE, ACC_ADD64, OP_NONE, J_NEXT,    PC_START};
            4'd13: c = '{MA_NONE, MB_NONE, ACC_NONE, OP_POWER, J_IF_NOVER, PC_TERM};
            4'd14: c = '{MA_NONE, MB_NONE, ACC_NONE, OP_DONE, J_NEXT,     PC_START};
            default: c = CTRL_NOP;
        endcase
        return c;
    endfunction

    assign cw   = busy_reg ? micro_rom(pc_reg) : CTRL_NOP;
    assign busy = busy_reg;
    assign done = busy_reg && (cw.dp_op == OP_DONE) && !hold;

    always_comb
    begin
        case (cw.jmp)
            J_NEXT:     take = 1'b0;
            J_IF_NZERO: take = stat.n_zero;
            J_IF_END:   take = stat.over || stat.last_term;
            J_IF_NOVER: take = !stat.over;
            default:    take = 1'b0;
        endcase

        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            pc_next   = PC_START;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cw.dp_op == OP_DONE)
            begin
                if (!hold)
                begin
                    pc_next   = PC_START;
                    busy_next = 1'b0;
                end
            end
            else if (take)
            begin
                pc_next = cw.target;
            end
            else
            begin
                pc_next = pc_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= PC_START;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ----- design/ttay_dp.sv -----
// Datapath: shared 32x32 multiplier, 128-bit accumulator, power and sum registers.
module ttay_dp #(
    parameter int MAX_TERMS = 13
) (
    input  logic                           clk,
    input  logic                           start,
    input  logic [ttay_pkg::ANGLE_W-1:0]   angle,
    input  logic [ttay_pkg::TERM_W-1:0]    term_count,
    input  ttay_pkg::ctrl_t                cw,
    output ttay_pkg::stat_t                stat,
    output logic [ttay_pkg::OUT_W-1:0]     tangent,
    output logic                           saturated
);
    import ttay_pkg::*;

    logic [ANGLE_W-1:0] mag_reg,  mag_next;
    logic               neg_reg,  neg_next;
    logic [TERM_W-1:0]  n_reg,    n_next;
    logic [TERM_W-1:0]  k_reg,    k_next;
    logic [63:0]        p_reg,    p_next;
    logic [63:0]        x2_reg,   x2_next;
    logic [63:0]        prod_reg, prod_next;
    logic [127:0]       acc_reg,  acc_next;
    logic [OUT_W-1:0]   sum_reg,  sum_next;
    logic               sat_reg,  sat_next;

    logic [31:0]        op_a;
    logic [31:0]        op_b;
    logic [63:0]        coef;
    logic [OUT_W-1:0]   limit;
    logic [OUT_W:0]     sum_ext;
    logic               over_term;
    logic               over_pow;
    logic [OUT_W-1:0]   final_mag;
    logic [ANGLE_W-1:0] angle_mag;
    logic [TERM_W-1:0]  n_clamp;

    assign coef  = (k_reg < TERM_W'(ROM_SIZE)) ? COEF_ROM[k_reg] : 64'd0;
    assign limit = neg_reg ? LIMIT_NEG : LIMIT_POS;

    always_comb
    begin
        case (cw.mul_a)
            MA_MAG:  op_a = mag_reg;
            MA_PLO:  op_a = p_reg[31:0];
            MA_PHI:  op_a = p_reg[63:32];
            default: op_a = 32'd0;
        endcase
        case (cw.mul_b)
            MB_MAG:  op_b = mag_reg;
            MB_CLO:  op_b = coef[31:0];
            MB_CHI:  op_b = coef[63:32];
            MB_XLO:  op_b = x2_reg[31:0];
            MB_XHI:  op_b = x2_reg[63:32];
            default: op_b = 32'd0;
        endcase
    end

    // The term is acc[127:62]; the sum bound also covers a term above the limit.
    assign sum_ext   = {1'b0, sum_reg} + {1'b0, acc_reg[109:62]};
    assign over_term = (|acc_reg[127:110]) || (sum_ext > {1'b0, limit});
    assign over_pow  = |acc_reg[127:122];

    assign stat.n_zero    = (n_reg == '0);
    assign stat.last_term = ((k_reg + 4'd1) == n_reg);
    assign stat.over      = (cw.dp_op == OP_POWER) ? over_pow : over_term;

    assign final_mag = sat_reg ? limit : sum_reg;
    assign tangent   = neg_reg ? (~final_mag + 48'd1) : final_mag;
    assign saturated = sat_reg;

    assign angle_mag = angle[ANGLE_W-1] ? (~angle + 32'd1) : angle;
    assign n_clamp   = (term_count > TERM_W'(MAX_TERMS)) ? TERM_W'(MAX_TERMS) : term_count;

    always_comb
    begin
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        n_next    = n_reg;
        k_next    = k_reg;
        p_next    = p_reg;
        x2_next   = x2_reg;
        prod_next = op_a * op_b;
        acc_next  = acc_reg;
        sum_next  = sum_reg;
        sat_next  = sat_reg;

        case (cw.acc_op)
            ACC_LOAD:  acc_next = {64'd0, prod_reg};
            ACC_ADD32: acc_next = acc_reg + {32'd0, prod_reg, 32'd0};
            ACC_ADD64: acc_next = acc_reg + {prod_reg, 64'd0};
            default:   acc_next = acc_reg;
        endcase

        case (cw.dp_op)
            OP_X2:
            begin
                x2_next = prod_reg;
            end
            OP_TERM:
            begin
                if (over_term)
                begin
                    sat_next = 1'b1;
                end
                else
                begin
                    sum_next = sum_ext[OUT_W-1:0];
                    k_next   = k_reg + 4'd1;
                end
            end
            OP_POWER:
            begin
                // A power past Q32.32 already saturates the next term.
                if (over_pow)
                    sat_next = 1'b1;
                else
                    p_next = acc_reg[121:58];
            end
            default:
            begin
            end
        endcase

        if (start)
        begin
            mag_next = angle_mag;
            neg_next = angle[ANGLE_W-1];
            n_next   = n_clamp;
            k_next   = '0;
            p_next   = {29'd0, angle_mag, 3'd0};
            sum_next = '0;
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        p_reg    <= p_next;
        x2_reg   <= x2_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        sum_reg  <= sum_next;
        sat_reg  <= sat_next;
    end

endmodule

// ----- design/tangent_taylor_series.sv -----
// The series sums n terms (n clamped to MAX_TERMS, 13 by default) and ends early when saturation
// is found; n = 0 skips straight to the result. An item is taken only while the sequencer is idle.
// Each term is four 32x32 partial products on the one shared multiplier, an accumulate step and
// a check step, and each power update takes another six steps.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst_n low, asynchronous) idles the sequencer and empties the output register.
`include "tangent_taylor_series_defines.svh"

module tangent_taylor_series #(
    parameter int MAX_TERMS = 13
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // angle [31:0], term_count [35:32], zero [39:36]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata     // tangent [47:0], saturated [48], zero [55:49]
);
    import ttay_pkg::*;

    ctrl_t            cw;
    stat_t            stat;
    logic             busy;
    logic             done;
    logic             start;
    logic             hold;
    logic [OUT_W-1:0] tangent;
    logic             saturated;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [55:0]      m_tdata_reg,  m_tdata_next;

    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready;
    assign hold     = m_tvalid_reg && !m_tready;

    ttay_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .hold  (hold),
        .stat  (stat),
        .cw    (cw),
        .busy  (busy),
        .done  (done)
    );

    ttay_dp #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .clk        (clk),
        .start      (start),
        .angle      (s_tdata[31:0]),
        .term_count (s_tdata[35:32]),
        .cw         (cw),
        .stat       (stat),
        .tangent    (tangent),
        .saturated  (saturated)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (done)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {7'd0, saturated, tangent};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `TTAY_ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy && !s_tready)
    `TTAY_ASSERT_NOW(a_done_slot_free, clk, rst_n, done, !hold)
    `TTAY_ASSERT_NEXT(a_done_valid, clk, rst_n, done, m_tvalid)
    `TTAY_ASSERT_NOW(a_sat_limit, clk, rst_n, m_tvalid && m_tdata[48],
                     m_tdata[47:0] == LIMIT_POS || m_tdata[47:0] == LIMIT_NEG)

endmodule
